// ===== src/acds_pkg.sv =====
// Shared types and constants for the ADC CV dynamic smoother.
// Used by every module of the block and by its checker.
package acds_pkg;

    localparam int SAMPLES_PER_SET_DEF = 8;

    localparam int CODE_W     = 16;
    localparam int Q_W        = 20;
    localparam int SCALE_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_IDX_W-1:0] REG_INPUT_BIAS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_SCALE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_MODE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_UNIT = 2'd3;

    localparam logic [CODE_W-1:0] BIAS_RESET = 16'd32768;
    localparam logic signed [SCALE_W-1:0] SCALE_RESET = -32'sd65574;

    localparam int G_BASE = 6554;
    localparam int G_SENS = 10;
    localparam int Q_ONE  = 65536;

    typedef struct packed {
        logic [CODE_W-1:0] sample;
        logic              last_of_set;
        logic              jack_present;
    } sample_t;

    typedef struct packed {
        logic [CODE_W-1:0]     set_value;
        logic signed [Q_W-1:0] smoothed_value;
    } result_t;

    typedef struct packed {
        logic [CODE_W-1:0]         input_bias;
        logic signed [SCALE_W-1:0] input_scale;
        logic                      peak_mode;
        logic                      clamp_unit;
    } cfg_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              jack;
    } job_t;

endpackage

// ===== src/adc_cv_dynamic_smoother.sv =====
// Top level of the ADC CV dynamic smoother: configuration registers, front
// end, job queue and back end. Depends on acds_pkg, acds_front, acds_fifo, acds_back.
//
// Samples are taken one per cycle while the two-entry job queue has room; a
// sample that closes a set turns into one result. The back end works on one
// set at a time through a seven-step sequence around a calibration multiplier
// and one multiplier shared by both smoother stages, and registers the result
// at its final update step. Sets with at least as many samples as the
// sequence has steps stream at one sample per cycle while results are taken;
// shorter back-to-back sets are paced by the back end. The result register
// lets the next set proceed up to its final update while a finished result
// waits to be taken. Configuration writes are always accepted and should
// only be made while no set is in flight.
module adc_cv_dynamic_smoother import acds_pkg::*; #(
    parameter int SAMPLES_PER_SET = SAMPLES_PER_SET_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    output logic                  sample_ready,
    input  sample_t               sample_item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output result_t               result_item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg_reg;
    logic push_valid, push_ready, job_valid, job_pop;
    job_t push_job, pop_job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.input_bias  <= BIAS_RESET;
            cfg_reg.input_scale <= SCALE_RESET;
            cfg_reg.peak_mode   <= 1'b0;
            cfg_reg.clamp_unit  <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_INPUT_BIAS:  cfg_reg.input_bias  <= cfg_data[CODE_W-1:0];
                REG_INPUT_SCALE: cfg_reg.input_scale <= cfg_data[SCALE_W-1:0];
                REG_PEAK_MODE:   cfg_reg.peak_mode   <= cfg_data[0];
                REG_CLAMP_UNIT:  cfg_reg.clamp_unit  <= cfg_data[0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    acds_front #(
        .SAMPLES_PER_SET(SAMPLES_PER_SET)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .sample_valid(sample_valid),
        .sample_ready(sample_ready),
        .sample_item (sample_item),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_job    (push_job)
    );

    acds_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_job  (push_job),
        .pop_valid (job_valid),
        .pop       (job_pop),
        .pop_job   (pop_job)
    );

    acds_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .job_valid   (job_valid),
        .job_pop     (job_pop),
        .job         (pop_job),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result_item (result_item)
    );

endmodule

// ===== src/acds_front.sv =====
// Front end: accumulates the sum and peak of a sample set and hands the
// reduced code to the job queue when the set closes. Depends on acds_pkg.
module acds_front import acds_pkg::*; #(
    parameter int SAMPLES_PER_SET = SAMPLES_PER_SET_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    sample_valid,
    output logic    sample_ready,
    input  sample_t sample_item,
    output logic    push_valid,
    input  logic    push_ready,
    output job_t    push_job
);

    localparam int SHIFT = $clog2(SAMPLES_PER_SET);
    localparam int SUM_W = CODE_W + SHIFT;
    localparam logic [SUM_W:0] SUM_CAP = (SUM_W+1)'(((1 << CODE_W) - 1) * SAMPLES_PER_SET);

    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [CODE_W-1:0] peak_reg, peak_next;
    logic [SUM_W:0]    sum_add;
    logic [SUM_W-1:0]  sum_sat;
    logic [CODE_W-1:0] peak_max;
    logic              accept;

    assign accept       = sample_valid & push_ready;
    assign sample_ready = push_ready;

    always_comb
    begin
        sum_add  = {1'b0, sum_reg} + (SUM_W+1)'(sample_item.sample);
        sum_sat  = (sum_add > SUM_CAP) ? SUM_CAP[SUM_W-1:0] : sum_add[SUM_W-1:0];
        peak_max = (sample_item.sample > peak_reg) ? sample_item.sample : peak_reg;

        // The sum never exceeds the cap, so the average always fits the code width.
        push_job.code = cfg.peak_mode ? peak_max : sum_sat[SUM_W-1 -: CODE_W];
        push_job.jack = sample_item.jack_present;
        push_valid    = accept & sample_item.last_of_set;

        sum_next  = sum_reg;
        peak_next = peak_reg;
        if (accept)
        begin
            if (sample_item.last_of_set)
            begin
                sum_next  = '0;
                peak_next = '0;
            end
            else
            begin
                sum_next  = sum_sat;
                peak_next = peak_max;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            peak_reg <= '0;
        end
        else
        begin
            sum_reg  <= sum_next;
            peak_reg <= peak_next;
        end
    end

endmodule

// ===== src/acds_fifo.sv =====
// Short job queue between the front end and the calibration/smoother back end.
// Depends on acds_pkg for the job type and queue depth.
module acds_fifo import acds_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_job,
    output logic pop_valid,
    input  logic pop,
    output job_t pop_job
);

    job_t                mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign push_ready = (count_reg != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop & pop_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// ===== src/acds_back.sv =====
// Back end: a sequencer calibrates one reduced code and steps the two-stage
// dynamic smoother, whose stages share a multiplier. Depends on acds_pkg.
module acds_back import acds_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    job_valid,
    output logic    job_pop,
    input  job_t    job,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result_item
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_CAL  = 3'd2;
    localparam logic [2:0] ST_MUL1 = 3'd3;
    localparam logic [2:0] ST_UPD1 = 3'd4;
    localparam logic [2:0] ST_MUL2 = 3'd5;
    localparam logic [2:0] ST_UPD2 = 3'd6;

    localparam int DIFF_W = CODE_W + 1;
    localparam int PROD_W = DIFF_W + SCALE_W;
    localparam int CAL_W  = PROD_W - 15;
    localparam int G_W    = 17;
    localparam int T_W    = Q_W + 1;
    localparam int M_W    = T_W + G_W + 1;
    localparam int STEP_W = M_W - 16;
    localparam int BAND_W = Q_W + 5;

    localparam logic signed [Q_W-1:0] Q_MAX_V = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN_V = {1'b1, {(Q_W-1){1'b0}}};
    localparam logic signed [Q_W-1:0] Q_ONE_V = Q_W'(Q_ONE);

    logic [2:0]               st_reg, st_next;
    logic signed [DIFF_W-1:0] diff_reg;
    logic [CODE_W-1:0]        code_reg;
    logic                     jack_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [G_W-1:0]           g_reg;
    logic signed [Q_W-1:0]    x_reg;
    logic signed [M_W-1:0]    m_reg;
    logic signed [Q_W-1:0]    y1_reg, y2_reg;
    logic                     result_valid_reg, result_valid_next;
    result_t                  result_item_reg;

    logic signed [T_W-1:0]    dy;
    logic [T_W-1:0]           band;
    logic [BAND_W-1:0]        g_raw;
    logic [G_W-1:0]           g_new;
    logic signed [PROD_W-1:0] prod_rnd;
    logic signed [CAL_W-1:0]  cal_sh;
    logic signed [Q_W-1:0]    cal_sat, x_new;
    logic signed [T_W-1:0]    t_mul;
    logic signed [G_W:0]      g_s;
    logic signed [M_W-1:0]    m_prod;
    logic signed [Q_W-1:0]    y_old, y_new;
    logic                     out_free;

    // y + round(m / 2^16), ties up, saturated to the Q4.16 range.
    function automatic logic signed [Q_W-1:0] stage_step(
        input logic signed [Q_W-1:0] y,
        input logic signed [M_W-1:0] m
    );
        logic signed [M_W-1:0]    m_rnd;
        logic signed [STEP_W+1:0] s;
        begin
            m_rnd = m + M_W'(32768);
            s = (STEP_W+2)'(y) + (STEP_W+2)'($signed(m_rnd[M_W-1:16]));
            if (s > (STEP_W+2)'(Q_MAX_V))
                stage_step = Q_MAX_V;
            else if (s < (STEP_W+2)'(Q_MIN_V))
                stage_step = Q_MIN_V;
            else
                stage_step = s[Q_W-1:0];
        end
    endfunction

    assign out_free     = !result_valid_reg || result_ready;
    assign job_pop      = (st_reg == ST_IDLE) && job_valid;
    assign result_valid = result_valid_reg;
    assign result_item  = result_item_reg;

    always_comb
    begin
        // Smoother gain from the current spread between the two stages.
        dy    = T_W'(y2_reg) - T_W'(y1_reg);
        band  = dy[T_W-1] ? T_W'(-dy) : T_W'(dy);
        g_raw = BAND_W'(G_BASE) + BAND_W'(band) * BAND_W'(G_SENS);
        g_new = (g_raw > BAND_W'(Q_ONE)) ? G_W'(Q_ONE) : g_raw[G_W-1:0];

        prod_rnd = prod_reg + PROD_W'(16384);
        cal_sh   = prod_rnd[PROD_W-1:15];
        if (cal_sh > CAL_W'(Q_MAX_V))
            cal_sat = Q_MAX_V;
        else if (cal_sh < CAL_W'(Q_MIN_V))
            cal_sat = Q_MIN_V;
        else
            cal_sat = cal_sh[Q_W-1:0];
        x_new = cal_sat;
        if (cfg.clamp_unit)
        begin
            if (cal_sat > Q_ONE_V)
                x_new = Q_ONE_V;
            else if (cal_sat < -Q_ONE_V)
                x_new = -Q_ONE_V;
        end
        if (!jack_reg)
            x_new = '0;

        if (st_reg == ST_MUL1)
            t_mul = T_W'(x_reg) - T_W'(y1_reg);
        else
            t_mul = T_W'(y1_reg) - T_W'(y2_reg);
        g_s    = {1'b0, g_reg};
        m_prod = M_W'(t_mul) * M_W'(g_s);

        y_old = (st_reg == ST_UPD1) ? y1_reg : y2_reg;
        y_new = stage_step(y_old, m_reg);

        st_next = st_reg;
        case (st_reg)
            ST_IDLE: if (job_valid) st_next = ST_MUL;
            ST_MUL:  st_next = ST_CAL;
            ST_CAL:  st_next = ST_MUL1;
            ST_MUL1: st_next = ST_UPD1;
            ST_UPD1: st_next = ST_MUL2;
            ST_MUL2: st_next = ST_UPD2;
            ST_UPD2: if (out_free) st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase

        result_valid_next = result_valid_reg && !result_ready;
        if (st_reg == ST_UPD2 && out_free)
            result_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg           <= ST_IDLE;
            y1_reg           <= '0;
            y2_reg           <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg           <= st_next;
            result_valid_reg <= result_valid_next;
            if (st_reg == ST_UPD1)
                y1_reg <= y_new;
            if (st_reg == ST_UPD2 && out_free)
                y2_reg <= y_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            diff_reg <= DIFF_W'(job.code) - DIFF_W'(cfg.input_bias);
            code_reg <= job.code;
            jack_reg <= job.jack;
            g_reg    <= g_new;
        end
        if (st_reg == ST_MUL)
            prod_reg <= PROD_W'(diff_reg) * PROD_W'(cfg.input_scale);
        if (st_reg == ST_CAL)
            x_reg <= x_new;
        if (st_reg == ST_MUL1 || st_reg == ST_MUL2)
            m_reg <= m_prod;
        if (st_reg == ST_UPD2 && out_free)
        begin
            result_item_reg.set_value      <= code_reg;
            result_item_reg.smoothed_value <= y_new;
        end
    end

endmodule

// ===== src/acds_checker.sv =====
// Port-level checker for the ADC CV dynamic smoother, bound to the top level.
// Depends on acds_pkg and adc_cv_dynamic_smoother.
module acds_checker import acds_pkg::*; (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  sample_valid,
    input logic                  sample_ready,
    input sample_t               sample_item,
    input logic                  result_valid,
    input logic                  result_ready,
    input result_t               result_item,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data
);

    // Sets closed at the input whose results have not yet been taken.
    logic [2:0] pending_reg, pending_next;
    logic       set_in, res_out;

    assign set_in  = sample_valid && sample_ready && sample_item.last_of_set;
    assign res_out = result_valid && result_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (set_in && !res_out)
            pending_next = pending_reg + 1'b1;
        else if (res_out && !set_in)
            pending_next = pending_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_next;
    end

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_item))
        else $error("result changed or dropped while stalled");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> pending_reg != 3'd0)
        else $error("result offered without a closed set");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd4)
        else $error("more sets in flight than queue and stages can hold");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !sample_ready |-> pending_reg >= 3'd2)
        else $error("input stalled while the job queue has room");

    // Register writes are never refused and carry a known index and value.
    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready && !$isunknown({cfg_index, cfg_data}))
        else $error("configuration write refused or undefined");

endmodule

bind adc_cv_dynamic_smoother acds_checker u_acds_checker (.*);

// ===== dv/adc_cv_dynamic_smoother_tb.sv =====
// Self-checking testbench for adc_cv_dynamic_smoother: set reduction,
// calibration, clamping and the two-stage dynamic smoother.
// Depends on acds_pkg and the RTL under src; it needs no other file.
module adc_cv_dynamic_smoother_tb;
    import acds_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     SET_LEN      = SAMPLES_PER_SET_DEF;
    localparam int     SUM_W        = CODE_W + $clog2(SET_LEN + 1);
    localparam longint SUM_CAP      = 65535 * SET_LEN;
    localparam longint Q_MAX        = (64'sd1 <<< (Q_W - 1)) - 1;
    localparam longint Q_MIN        = -(64'sd1 <<< (Q_W - 1));
    localparam int     SETTLE_CYCLES = 24;
    localparam int     STALL_LIMIT   = 2000;
    localparam int     PHASE_ITEMS   = 250;
    localparam int     RANDOM_PHASES = 8;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  sample_valid = 1'b0;
    logic                  sample_ready;
    sample_t               sample_item = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    result_t               result_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_INPUT_BIAS;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Our copy of the calibration registers and of the block state.
    logic [CODE_W-1:0]         cal_bias = BIAS_RESET;
    logic signed [SCALE_W-1:0] cal_scale = SCALE_RESET;
    logic                      cal_peak = 1'b0;
    logic                      cal_clamp = 1'b1;
    logic [SUM_W-1:0]          acc_sum = '0;
    logic [CODE_W-1:0]         acc_peak = '0;
    logic signed [Q_W-1:0]     stage_one = '0;
    logic signed [Q_W-1:0]     stage_two = '0;

    sample_t sample_backlog[$];
    result_t expected_readings[$];
    result_t want;
    int      mismatches = 0;
    int      send_wait = 0;
    int      recv_wait = 0;
    int      idle_cycles = 0;
    logic    steady = 1'b0;

    adc_cv_dynamic_smoother dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_item  (sample_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic longint sat_q(input longint v);
        if (v > Q_MAX)
            return Q_MAX;
        if (v < Q_MIN)
            return Q_MIN;
        return v;
    endfunction

    // Folds one accepted item into the set and, when it closes the set,
    // computes the reading that the block must return.
    function automatic void smoother_step(input sample_t s);
        longint  sum_v;
        longint  code_v;
        longint  x;
        longint  band;
        longint  g;
        longint  y1;
        longint  y2;
        result_t r;
        sum_v = longint'(acc_sum) + longint'(s.sample);
        if (sum_v > SUM_CAP)
            sum_v = SUM_CAP;
        acc_sum = sum_v[SUM_W-1:0];
        if (s.sample > acc_peak)
            acc_peak = s.sample;
        if (!s.last_of_set)
            return;
        if (cal_peak)
            code_v = longint'(acc_peak);
        else
            code_v = longint'(acc_sum) / SET_LEN;
        if (code_v > 65535)
            code_v = 65535;
        acc_sum = '0;
        acc_peak = '0;
        x = (code_v - longint'(cal_bias)) * longint'(cal_scale);
        x = sat_q((x + 16384) >>> 15);
        if (cal_clamp)
        begin
            if (x > Q_ONE)
                x = Q_ONE;
            if (x < -Q_ONE)
                x = -Q_ONE;
        end
        if (!s.jack_present)
            x = 0;
        y1 = longint'(stage_one);
        y2 = longint'(stage_two);
        band = (y2 > y1) ? y2 - y1 : y1 - y2;
        g = G_BASE + G_SENS * band;
        if (g > Q_ONE)
            g = Q_ONE;
        y1 = sat_q(y1 + (((x - y1) * g + 32768) >>> 16));
        y2 = sat_q(y2 + (((y1 - y2) * g + 32768) >>> 16));
        stage_one = y1[Q_W-1:0];
        stage_two = y2[Q_W-1:0];
        r.set_value = code_v[CODE_W-1:0];
        r.smoothed_value = y2[Q_W-1:0];
        expected_readings.push_back(r);
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Sender: one item at a time from the backlog, with a random gap between items outside the steady phases.
    always @(posedge clk)
    begin
        if (sample_valid && sample_ready)
        begin
            smoother_step(sample_item);
            send_wait = steady ? 0 : $urandom_range(0, 3);
        end
        if (!sample_valid || sample_ready)
        begin
            if (send_wait > 0)
            begin
                send_wait--;
                sample_valid <= 1'b0;
            end
            else if (rst_n && sample_backlog.size() > 0)
            begin
                sample_item <= sample_backlog.pop_front();
                sample_valid <= 1'b1;
            end
            else
            begin
                sample_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each reading against the oldest prediction.
    always @(posedge clk)
    begin
        if (result_valid && result_ready)
        begin
            recv_wait = steady ? 0 : $urandom_range(0, 3);
            if (expected_readings.size() == 0)
            begin
                flag_mismatch($sformatf("reading with nothing expected: set_value %0d",
                    result_item.set_value));
            end
            else
            begin
                want = expected_readings.pop_front();
                if (result_item.set_value !== want.set_value)
                    flag_mismatch($sformatf("set_value %0d, expected %0d",
                        result_item.set_value, want.set_value));
                if (result_item.smoothed_value !== want.smoothed_value)
                    flag_mismatch($sformatf("smoothed_value %0d, expected %0d",
                        result_item.smoothed_value, want.smoothed_value));
            end
        end
        if (recv_wait > 0)
        begin
            if (result_valid)
                recv_wait--;
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((sample_valid && sample_ready) || (result_valid && result_ready)
            || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == STALL_LIMIT)
        begin
            $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_INPUT_BIAS:  cal_bias = data[CODE_W-1:0];
            REG_INPUT_SCALE: cal_scale = data[SCALE_W-1:0];
            REG_PEAK_MODE:   cal_peak = data[0];
            REG_CLAMP_UNIT:  cal_clamp = data[0];
            default: ;
        endcase
    endtask

    // Waits until the backlog is sent and every expected reading is taken,
    // then lets the block settle before anything else happens.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (sample_backlog.size() != 0 || sample_valid || expected_readings.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_sample(input logic [CODE_W-1:0] value, input logic last, input logic jack);
        sample_t s;
        s.sample = value;
        s.last_of_set = last;
        s.jack_present = jack;
        sample_backlog.push_back(s);
    endtask

    task automatic queue_set(input int len);
        logic [CODE_W-1:0] value;
        int                pick;
        for (int i = 0; i < len; i++)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                value = '0;
            else if (pick == 1)
                value = '1;
            else if (pick < 5)
                value = cal_bias + CODE_W'($urandom_range(0, 1023)) - CODE_W'(512);
            else
                value = CODE_W'($urandom_range(0, 65535));
            queue_sample(value, i == len - 1, $urandom_range(0, 7) != 0);
        end
    endtask

    initial
    begin
        int                  items;
        int                  len;
        logic [CODE_W-1:0]   bias_v;
        logic [SCALE_W-1:0]  scale_v;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset calibration: a full set of edge codes, a one-sample set with
        // the jack out, and a long set of full-scale codes that saturates the sum.
        queue_sample(16'h0000, 1'b0, 1'b1);
        queue_sample(16'hFFFF, 1'b0, 1'b1);
        queue_sample(16'h5555, 1'b0, 1'b0);
        queue_sample(16'hAAAA, 1'b0, 1'b1);
        queue_sample(16'h0001, 1'b0, 1'b1);
        queue_sample(16'h8000, 1'b0, 1'b1);
        queue_sample(16'h7FFF, 1'b0, 1'b1);
        queue_sample(16'hFFFF, 1'b1, 1'b1);
        queue_sample(16'hFFFF, 1'b1, 1'b0);
        for (int i = 0; i < 10; i++)
            queue_sample(16'hFFFF, i == 9, 1'b1);
        wait_drained();

        // Peak of the set, no clamp, extreme gain in both directions.
        write_reg(REG_PEAK_MODE, 1);
        write_reg(REG_CLAMP_UNIT, 0);
        write_reg(REG_INPUT_BIAS, 0);
        write_reg(REG_INPUT_SCALE, 32'h7FFF_FFFF);
        @(negedge clk);
        queue_sample(16'd100, 1'b0, 1'b1);
        queue_sample(16'hFFFF, 1'b1, 1'b1);
        wait_drained();
        write_reg(REG_INPUT_BIAS, 32'h0000_FFFF);
        write_reg(REG_INPUT_SCALE, 32'h8000_0000);
        @(negedge clk);
        queue_sample(16'h0000, 1'b1, 1'b1);
        queue_sample(16'h0000, 1'b1, 1'b0);
        wait_drained();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case ($urandom_range(0, 3))
                0:       bias_v = '0;
                1:       bias_v = '1;
                default: bias_v = CODE_W'($urandom_range(0, 65535));
            endcase
            case ($urandom_range(0, 4))
                0:       scale_v = 32'h7FFF_FFFF;
                1:       scale_v = 32'h8000_0000;
                2:       scale_v = $urandom;
                default: scale_v = SCALE_W'(int'($urandom_range(0, 262143)) - 131072);
            endcase
            write_reg(REG_INPUT_BIAS, CFG_DATA_W'(bias_v));
            write_reg(REG_INPUT_SCALE, scale_v);
            write_reg(REG_PEAK_MODE, $urandom_range(0, 1));
            write_reg(REG_CLAMP_UNIT, $urandom_range(0, 1));
            @(negedge clk);
            steady = (phase % 4 == 2);
            items = 0;
            // Mostly whole sets, with short and overlong ones mixed in.
            while (items < PHASE_ITEMS)
            begin
                len = ($urandom_range(0, 4) != 0) ? SET_LEN : $urandom_range(1, SET_LEN + 4);
                queue_set(len);
                items += len;
            end
            wait_drained();
        end

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
